// ----- sv/ppq_pkg.sv -----
// ----------------------------------------------------------------------------
// ppq_pkg
// Shared types and constants of the ping-pong ring queue: request and
// response beats, memory command group, register map and defaults.
// ----------------------------------------------------------------------------
package ppq_pkg;

    // Default geometry
    localparam int DEF_BANK_DEPTH = 256;
    localparam int DEF_DATA_WIDTH = 32;

    // Fixed beat field widths
    localparam int REQ_TYPE_W = 1;
    localparam int WORD_W     = 32;

    // Configuration register map
    localparam int   CAP_W          = 9;
    localparam int   ADDR_W         = 3;
    localparam int   APB_DATA_W     = 32;
    localparam logic REG_IDX_CAPACITY = 1'b0;
    localparam logic [CAP_W-1:0] CAPACITY_RESET = 9'd256;

    // Request codes
    localparam logic [REQ_TYPE_W-1:0] REQ_ENQ = 1'b0;
    localparam logic [REQ_TYPE_W-1:0] REQ_DEQ = 1'b1;

    // Input beat
    typedef struct packed {
        logic [REQ_TYPE_W-1:0] req_type;
        logic [WORD_W-1:0]     push_data;
    } t_req;

    // Output beat
    typedef struct packed {
        logic              pop_ok;
        logic [WORD_W-1:0] pop_data;
    } t_rsp;

    // Control group from the pointer logic to the bank memory
    typedef struct packed {
        logic wr_en;
        logic wr_bank;
        logic rd_en;
        logic rd_bank;
    } t_mem_cmd;

endpackage

// ----- sv/ping_pong_ring_queue.sv -----
// ----------------------------------------------------------------------------
// ping_pong_ring_queue
// Two-bank ring queue with APB capacity register.
// ----------------------------------------------------------------------------
// An enqueue beat writes the word into the bank memory at the write bank's
// head. A dequeue beat issues one read of the shared bank memory; its data
// returns through the registered read port and is loaded into the response register, so a
// dequeue holds the request side (o_in_stall) until that load, longer while
// the response side stalls a previous result. The memory read latency sets
// this; enqueues run at one beat per cycle while no dequeue is pending.
// Beats are taken while a finished result waits to be drained.
// Every dequeue yields one response beat; pop_ok low with pop_data zero
// means both banks were empty. The capacity register (byte address 0) sets
// the wrap point of both banks; write it only while the queue is idle.
// ----------------------------------------------------------------------------
module ping_pong_ring_queue #(
    parameter int BANK_DEPTH = ppq_pkg::DEF_BANK_DEPTH,
    parameter int DATA_WIDTH = ppq_pkg::DEF_DATA_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // request channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  ppq_pkg::t_req                  i_in_data,
    // response channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output ppq_pkg::t_rsp                  o_out_data,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ppq_pkg::ADDR_W-1:0]     paddr,
    input  logic [ppq_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ppq_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    localparam int PTR_W = $clog2(BANK_DEPTH);

    logic [ppq_pkg::CAP_W-1:0] r_capacity;
    logic                      reg_idx;
    ppq_pkg::t_mem_cmd         mem_cmd;
    logic [PTR_W-1:0]          wr_ptr;
    logic [PTR_W-1:0]          rd_ptr;
    logic [DATA_WIDTH-1:0]     wr_data;
    logic [DATA_WIDTH-1:0]     rd_data;

    // Register decode: paddr[2] picks the word; word 0 is the capacity register, word 1 reads zero
    assign reg_idx = paddr[2];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= ppq_pkg::CAPACITY_RESET;
        end else if (psel && penable && pwrite && pready
                     && (reg_idx == ppq_pkg::REG_IDX_CAPACITY)) begin
            r_capacity <= pwdata[ppq_pkg::CAP_W-1:0];
        end
    end

    always_comb begin
        unique case (reg_idx)
            ppq_pkg::REG_IDX_CAPACITY: prdata = ppq_pkg::APB_DATA_W'(r_capacity);
            default:                   prdata = '0;
        endcase
    end

    ppq_ctrl #(
        .BANK_DEPTH (BANK_DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_capacity  (r_capacity),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .o_cmd       (mem_cmd),
        .o_wr_ptr    (wr_ptr),
        .o_rd_ptr    (rd_ptr),
        .o_wr_data   (wr_data),
        .i_rd_data   (rd_data)
    );

    ppq_bank_mem #(
        .BANK_DEPTH (BANK_DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_cmd     (mem_cmd),
        .i_wr_ptr  (wr_ptr),
        .i_rd_ptr  (rd_ptr),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

endmodule

// ----- sv/ppq_bank_mem.sv -----
// ----------------------------------------------------------------------------
// ppq_bank_mem
// Word storage for both ring banks: one write and one read port, read data
// registered.
// ----------------------------------------------------------------------------
module ppq_bank_mem #(
    parameter int BANK_DEPTH = ppq_pkg::DEF_BANK_DEPTH,
    parameter int DATA_WIDTH = ppq_pkg::DEF_DATA_WIDTH,
    localparam int PTR_W     = $clog2(BANK_DEPTH)
) (
    input  logic                  i_clk,
    input  ppq_pkg::t_mem_cmd     i_cmd,
    input  logic [PTR_W-1:0]      i_wr_ptr,
    input  logic [PTR_W-1:0]      i_rd_ptr,
    input  logic [DATA_WIDTH-1:0] i_wr_data,
    output logic [DATA_WIDTH-1:0] o_rd_data
);

    logic [DATA_WIDTH-1:0] r_mem [2][BANK_DEPTH];
    logic [DATA_WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_cmd.wr_bank][i_wr_ptr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_cmd.rd_bank][i_rd_ptr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- sv/ppq_ctrl.sv -----
// ----------------------------------------------------------------------------
// ppq_ctrl
// Bank pointers, full flags and write-bank select; issues memory commands,
// waits for the registered pop data and holds the response beat.
// ----------------------------------------------------------------------------
module ppq_ctrl #(
    parameter int BANK_DEPTH = ppq_pkg::DEF_BANK_DEPTH,
    parameter int DATA_WIDTH = ppq_pkg::DEF_DATA_WIDTH,
    localparam int PTR_W     = $clog2(BANK_DEPTH)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [ppq_pkg::CAP_W-1:0]  i_capacity,
    // request side
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  ppq_pkg::t_req              i_in_data,
    // response side
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output ppq_pkg::t_rsp              o_out_data,
    // memory side
    output ppq_pkg::t_mem_cmd          o_cmd,
    output logic [PTR_W-1:0]           o_wr_ptr,
    output logic [PTR_W-1:0]           o_rd_ptr,
    output logic [DATA_WIDTH-1:0]      o_wr_data,
    input  logic [DATA_WIDTH-1:0]      i_rd_data
);

    // Wide enough for the capacity register and for BANK_DEPTH itself
    localparam int DEPTH_W = $clog2(BANK_DEPTH + 1);
    localparam int CW      = (DEPTH_W > ppq_pkg::CAP_W) ? DEPTH_W : ppq_pkg::CAP_W;

    logic [PTR_W-1:0] r_head [2];
    logic [PTR_W-1:0] r_tail [2];
    logic             r_full [2];
    logic             r_wbank;
    logic             r_pend;
    logic             r_pend_ok;
    logic             r_out_valid;
    ppq_pkg::t_rsp    r_out_data;

    logic [PTR_W-1:0] n_head [2];
    logic [PTR_W-1:0] n_tail [2];
    logic             n_full [2];
    logic             n_wbank;

    logic             acc;
    logic             is_enq;
    logic             wb;
    logic             rb;
    logic             ne_wb;
    logic             ne_rb;
    logic             pop_any;
    logic             pop_bank;
    logic             push_full;
    logic             out_free;
    logic [CW-1:0]    cap_raw;
    logic [CW-1:0]    eff_cap;

    // Pointer step: wrap to zero once the increment reaches the capacity
    function automatic logic [PTR_W-1:0] f_adv(input logic [PTR_W-1:0] p,
                                               input logic [CW-1:0]    cap);
        logic [CW-1:0] n;
        n = CW'(p) + CW'(1);
        return (n >= cap) ? '0 : PTR_W'(n);
    endfunction

    // Effective capacity: zero acts as one, clamp at the bank depth
    always_comb begin
        cap_raw = CW'(i_capacity);
        if (cap_raw == '0) begin
            eff_cap = CW'(1);
        end else if (cap_raw > CW'(BANK_DEPTH)) begin
            eff_cap = CW'(BANK_DEPTH);
        end else begin
            eff_cap = cap_raw;
        end
    end

    // Handshake
    assign o_in_stall = r_pend;
    assign acc        = i_in_valid && !r_pend;
    assign is_enq     = (i_in_data.req_type == ppq_pkg::REQ_ENQ);
    assign out_free   = !r_out_valid || !i_out_stall;

    // Bank roles and emptiness
    assign wb       = r_wbank;
    assign rb       = ~r_wbank;
    assign ne_wb    = !((r_tail[wb] == r_head[wb]) && !r_full[wb]);
    assign ne_rb    = !((r_tail[rb] == r_head[rb]) && !r_full[rb]);
    assign pop_any  = ne_rb || ne_wb;
    assign pop_bank = ne_rb ? rb : wb;

    // Next pointer state for the accepted beat
    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_full    = r_full;
        n_wbank   = r_wbank;
        push_full = 1'b0;
        if (acc) begin
            if (is_enq) begin
                n_head[wb] = f_adv(r_head[wb], eff_cap);
                push_full  = r_full[wb] || (n_head[wb] == r_tail[wb]);
                n_full[wb] = push_full;
                if (push_full) begin
                    n_wbank = rb;
                end
            end else begin
                // read bank empty: swap roles, old write bank now serves reads
                if (!ne_rb) begin
                    n_wbank = rb;
                end
                if (pop_any) begin
                    n_tail[pop_bank] = f_adv(r_tail[pop_bank], eff_cap);
                    n_full[pop_bank] = 1'b0;
                end
            end
        end
    end

    // Memory commands
    always_comb begin
        o_cmd.wr_en   = acc && is_enq;
        o_cmd.wr_bank = wb;
        o_cmd.rd_en   = acc && !is_enq && pop_any;
        o_cmd.rd_bank = pop_bank;
    end
    assign o_wr_ptr  = r_head[wb];
    assign o_rd_ptr  = r_tail[pop_bank];
    assign o_wr_data = DATA_WIDTH'(i_in_data.push_data);

    // State, pending pop and response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '{default: '0};
            r_tail      <= '{default: '0};
            r_full      <= '{default: 1'b0};
            r_wbank     <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_full  <= n_full;
            r_wbank <= n_wbank;
            if (acc && !is_enq) begin
                r_pend <= 1'b1;
            end else if (r_pend && out_free) begin
                r_pend <= 1'b0;
            end
            if (r_pend && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (acc && !is_enq) begin
            r_pend_ok <= pop_any;
        end
        if (r_pend && out_free) begin
            r_out_data.pop_ok   <= r_pend_ok;
            r_out_data.pop_data <= r_pend_ok ? ppq_pkg::WORD_W'(i_rd_data) : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Checks
    a_deq_pends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && !is_enq) |=> r_pend)
        else $error("dequeue beat did not start a pending read");

    a_valid_from_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_pend))
        else $error("response raised without a pending read");

    a_one_port_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.wr_en && o_cmd.rd_en))
        else $error("memory read and write issued together");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.pop_ok) |-> (o_out_data.pop_data == '0))
        else $error("failed pop carries nonzero data");

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ping-pong ring queue. Push and pop beats go in
// over the request channel and pop results are checked against a shadow of
// the two banks, their pointers, full flags and write-bank bit. The run
// covers capacity settings between 0 and 511, fills and overwrites both
// banks, and mixes idle cycles and back-pressure on both channels.
// ----------------------------------------------------------------------------
module tb;

    localparam int BANK_DEPTH  = ppq_pkg::DEF_BANK_DEPTH;
    localparam int DRAIN_GUARD = 8;

    logic          i_clk = 1'b0;
    logic          i_rst_n;
    logic          i_in_valid;
    logic          o_in_stall;
    ppq_pkg::t_req i_in_data;
    logic          o_out_valid;
    logic          i_out_stall = 1'b0;
    ppq_pkg::t_rsp o_out_data;
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [ppq_pkg::ADDR_W-1:0]     paddr;
    logic [ppq_pkg::APB_DATA_W-1:0] pwdata;
    logic [ppq_pkg::APB_DATA_W-1:0] prdata;
    logic          pready;

    int send_idle_pct = 0;
    int out_stall_pct = 0;
    int cap_writes    = 0;

    // Shadow of both banks; predicts every pop beat and matches it in order
    class bank_pair_tracker;
        logic [ppq_pkg::WORD_W-1:0] words [2][BANK_DEPTH];
        bit   written [2][BANK_DEPTH];
        int   head [2];
        int   tail [2];
        bit   full [2];
        bit   wr_bank;
        int   capacity;
        ppq_pkg::t_rsp pops_due [$];
        int   mismatches;
        int   n_enq;
        int   n_deq;
        int   n_hit;
        int   n_empty;

        function new();
            capacity = ppq_pkg::CAPACITY_RESET;
        endfunction

        function void set_capacity(logic [ppq_pkg::CAP_W-1:0] v);
            capacity = v;
        endfunction

        // 0 acts as 1, anything past the bank depth acts as the depth
        function int wrap_limit();
            int c;
            c = capacity;
            if (c < 1) c = 1;
            if (c > BANK_DEPTH) c = BANK_DEPTH;
            return c;
        endfunction

        // compare-based wrap, so a pointer above a lowered capacity drops to 0
        function int step_ptr(int p);
            int n;
            n = p + 1;
            return (n >= wrap_limit()) ? 0 : n;
        endfunction

        function bit holds_data(bit b);
            return !(tail[b] == head[b] && !full[b]);
        endfunction

        function void push_word(bit b, logic [ppq_pkg::WORD_W-1:0] w);
            words[b][head[b] % BANK_DEPTH]   = w;
            written[b][head[b] % BANK_DEPTH] = 1'b1;
            head[b] = step_ptr(head[b]);
            if (head[b] == tail[b]) full[b] = 1'b1;
        endfunction

        function bit pop_word(bit b, output logic [ppq_pkg::WORD_W-1:0] w);
            w = '0;
            if (!holds_data(b)) return 1'b0;
            w = words[b][tail[b] % BANK_DEPTH];
            tail[b] = step_ptr(tail[b]);
            full[b] = 1'b0;
            return 1'b1;
        endfunction

        // a dequeue now would only read entries that were written before
        function bit dequeue_in_contract();
            bit rb;
            rb = ~wr_bank;
            if (holds_data(rb)) return written[rb][tail[rb] % BANK_DEPTH];
            if (holds_data(wr_bank)) return written[wr_bank][tail[wr_bank] % BANK_DEPTH];
            return 1'b1;
        endfunction

        // accepted request beat: update the banks, queue the pop it causes
        function void apply_request(ppq_pkg::t_req r);
            bit                         wb;
            bit                         ok;
            logic [ppq_pkg::WORD_W-1:0] w;
            ppq_pkg::t_rsp              due;
            if (r.req_type == ppq_pkg::REQ_ENQ) begin
                n_enq++;
                wb = wr_bank;
                push_word(wb, r.push_data);
                if (full[wb]) wr_bank = ~wb;
            end else begin
                n_deq++;
                ok = pop_word(~wr_bank, w);
                if (!ok) begin
                    wb = wr_bank;
                    wr_bank = ~wb;
                    ok = pop_word(wb, w);
                end
                due.pop_ok   = ok;
                due.pop_data = ok ? w : '0;
                pops_due.push_back(due);
            end
        endfunction

        // accepted response beat: compare with the oldest pop still due
        function void match_pop(ppq_pkg::t_rsp got);
            ppq_pkg::t_rsp want;
            if (pops_due.size() == 0) begin
                $error("pop beat with no dequeue outstanding: pop_ok %0d pop_data %08h",
                       got.pop_ok, got.pop_data);
                mismatches++;
                return;
            end
            want = pops_due.pop_front();
            if (want.pop_ok) n_hit++;
            else n_empty++;
            if (got.pop_ok !== want.pop_ok) begin
                $error("pop_ok: expected %0d, actual %0d", want.pop_ok, got.pop_ok);
                mismatches++;
            end
            if (got.pop_data !== want.pop_data) begin
                $error("pop_data: expected %08h, actual %08h", want.pop_data, got.pop_data);
                mismatches++;
            end
        endfunction
    endclass

    bank_pair_tracker sb;

    ping_pong_ring_queue uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Response side back-pressure
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    // Response monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.match_pop(o_out_data);
        end
    end

    // Hard stop in case the queue hangs
    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic ppq_pkg::t_req make_req(logic [ppq_pkg::REQ_TYPE_W-1:0] kind,
                                               logic [ppq_pkg::WORD_W-1:0] w);
        ppq_pkg::t_req r;
        r.req_type  = kind;
        r.push_data = w;
        return r;
    endfunction

    // Random beat; falls back to a push when a pop would hit an unwritten entry
    function automatic ppq_pkg::t_req next_request(int enq_pct);
        ppq_pkg::t_req r;
        r.push_data = $urandom;
        if ($urandom_range(99) < enq_pct || !sb.dequeue_in_contract()) begin
            r.req_type = ppq_pkg::REQ_ENQ;
        end else begin
            r.req_type = ppq_pkg::REQ_DEQ;
        end
        return r;
    endfunction

    // Present one request beat until taken, then maybe leave an idle gap
    task automatic send_req(ppq_pkg::t_req r);
        i_in_data  <= r;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        sb.apply_request(r);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    // Hold off the sender until every pop has come back and the drain guard has passed
    task automatic drain_queue();
        i_in_valid <= 1'b0;
        while (sb.pops_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_GUARD) @(posedge i_clk);
    endtask

    // APB write of the capacity register (setup, then access phase); upper data bits are noise
    task automatic write_capacity(logic [ppq_pkg::CAP_W-1:0] cap);
        logic [ppq_pkg::APB_DATA_W-1:0] d;
        d = $urandom;
        d[ppq_pkg::CAP_W-1:0] = cap;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {ppq_pkg::REG_IDX_CAPACITY, 2'b00};
        pwdata  <= d;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_capacity(cap);
        cap_writes++;
    endtask

    // One random phase: capacity, idling mix, push share, beat count
    task automatic run_phase(logic [ppq_pkg::CAP_W-1:0] cap, int s_idle, int r_stall,
                             int enq_pct, int n);
        drain_queue();
        write_capacity(cap);
        send_idle_pct = s_idle;
        out_stall_pct = r_stall;
        for (int i = 0; i < n; i++) begin
            if (i == n / 2) drain_queue();
            send_req(next_request(enq_pct));
        end
    endtask

    initial begin
        sb = new();
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty pops, extreme words, pops across the bank swap
        send_req(make_req(ppq_pkg::REQ_DEQ, 32'h0));
        send_req(make_req(ppq_pkg::REQ_ENQ, 32'h0000_0000));
        send_req(make_req(ppq_pkg::REQ_ENQ, 32'hFFFF_FFFF));
        send_req(make_req(ppq_pkg::REQ_DEQ, 32'hFFFF_FFFF));
        send_req(make_req(ppq_pkg::REQ_DEQ, 32'h0));
        send_req(make_req(ppq_pkg::REQ_DEQ, 32'h0));

        // fill both banks at full capacity, then overwrite a full bank
        for (int i = 0; i < 2 * BANK_DEPTH + 8; i++) begin
            send_req(make_req(ppq_pkg::REQ_ENQ, $urandom));
        end

        // capacity 0 acts as 1: every push fills a bank and swaps
        drain_queue();
        write_capacity('0);
        send_req(make_req(ppq_pkg::REQ_ENQ, 32'hA5A5_A5A5));
        send_req(make_req(ppq_pkg::REQ_ENQ, 32'h5A5A_5A5A));
        send_req(make_req(ppq_pkg::REQ_ENQ, 32'h0F0F_0F0F));
        repeat (4) send_req(make_req(ppq_pkg::REQ_DEQ, 32'h0));

        // capacity 2: two pushes fill one bank and the third spills into the other
        drain_queue();
        write_capacity(ppq_pkg::CAP_W'(2));
        repeat (3) send_req(make_req(ppq_pkg::REQ_ENQ, $urandom));
        repeat (3) send_req(make_req(ppq_pkg::REQ_DEQ, 32'h0));

        // random phases over capacities and idling mixes
        run_phase(ppq_pkg::CAP_W'(511), 0, 0, 40, 250);
        run_phase(ppq_pkg::CAP_W'(3), 77, 0, 55, 150);
        run_phase(ppq_pkg::CAP_W'(1), 0, 77, 50, 120);
        run_phase(ppq_pkg::CAP_W'(2), 38, 38, 50, 120);
        run_phase(ppq_pkg::CAP_W'($urandom_range(40, 4)), 0, 0, 50, 150);
        run_phase(ppq_pkg::CAP_W'(256), 77, 0, 50, 100);
        run_phase(ppq_pkg::CAP_W'(7), 0, 77, 60, 120);
        run_phase(ppq_pkg::CAP_W'($urandom_range(16, 1)), 38, 38, 50, 100);

        drain_queue();
        $display("Run covered %0d pushes and %0d pops over %0d capacity settings",
                 sb.n_enq, sb.n_deq, cap_writes);
        $display("Pops returned %0d words and %0d empty answers", sb.n_hit, sb.n_empty);
        if (sb.mismatches == 0 && sb.pops_due.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
